### src/mmcrc_pkg.sv
// shared types, constants and byte-wise crc update functions for the crc engine
`default_nettype none
package mmcrc_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SEED = 2'd1;

    localparam logic [1:0] MODE_CRC8  = 2'd0;
    localparam logic [1:0] MODE_CRC16 = 2'd1;
    localparam logic [1:0] MODE_CRC32 = 2'd2;

    localparam logic [7:0]  CRC8_POLY       = 8'h07;
    localparam logic [15:0] CRC16_INIT      = 16'hFFFF;
    localparam logic [31:0] CRC32_INIT      = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC32_POLY_REFL = 32'hEDB8_8320;

    localparam logic [2:0] BYTES_CRC8  = 3'd1;
    localparam logic [2:0] BYTES_CRC16 = 3'd2;
    localparam logic [2:0] BYTES_CRC32 = 3'd4;
    localparam logic [2:0] BYTES_NONE  = 3'd0;

    typedef enum logic [1:0] {
        OP_CRC8  = 2'd0,
        OP_CRC16 = 2'd1,
        OP_CRC32 = 2'd2,
        OP_ERROR = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] seed;
    } t_cfg;

    function automatic logic [31:0] start_value(input t_cfg cfg);
        logic [31:0] v;
        case (cfg.mode)
            MODE_CRC8:  v = {24'd0, cfg.seed};
            MODE_CRC16: v = {16'd0, CRC16_INIT};
            MODE_CRC32: v = CRC32_INIT;
            default:    v = 32'd0;
        endcase
        return v;
    endfunction

    // msb first, poly 0x07, one bit per step
    function automatic logic [7:0] crc8_update(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] x;
        x = c ^ b;
        for (int k = 0; k < 8; k++) begin
            if (x[7]) begin
                x = {x[6:0], 1'b0} ^ CRC8_POLY;
            end else begin
                x = {x[6:0], 1'b0};
            end
        end
        return x;
    endfunction

    // byte-wise ccitt shift formula
    function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
        logic [7:0] x;
        x = c[15:8] ^ b;
        x = x ^ {4'd0, x[7:4]};
        return {c[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
    endfunction

    // reflected, lsb first
    function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (x[0]) begin
                x = {1'b0, x[31:1]} ^ CRC32_POLY_REFL;
            end else begin
                x = {1'b0, x[31:1]};
            end
        end
        return x;
    endfunction

endpackage
`default_nettype wire

### src/mmcrc_front.sv
// front end: accepts bytes, tags them with the crc operation and queues them
`default_nettype none
module mmcrc_front #(
    parameter int QUEUE_DEPTH = mmcrc_pkg::QUEUE_DEPTH
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [7:0]          i_data_byte,
    input  wire                 i_last_byte,
    input  mmcrc_pkg::t_cfg     i_cfg,
    output logic                o_item_valid,
    output mmcrc_pkg::t_item    o_item,
    input  wire                 i_item_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    mmcrc_pkg::t_item r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    mmcrc_pkg::t_item w_item;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        case (i_cfg.mode)
            mmcrc_pkg::MODE_CRC8:  w_item.op = mmcrc_pkg::OP_CRC8;
            mmcrc_pkg::MODE_CRC16: w_item.op = mmcrc_pkg::OP_CRC16;
            mmcrc_pkg::MODE_CRC32: w_item.op = mmcrc_pkg::OP_CRC32;
            default:               w_item.op = mmcrc_pkg::OP_ERROR;
        endcase
        w_item.data = i_data_byte;
        w_item.last = i_last_byte;
    end

    assign o_ready      = (r_count != FULL_CNT);
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_queue[r_rd_ptr];
    assign w_push       = i_valid && o_ready;
    assign w_pop        = o_item_valid && i_item_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_item;
        end
    end

endmodule
`default_nettype wire

### src/mmcrc_back.sv
// back end: running crc register, byte update and result register
`default_nettype none
module mmcrc_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_item_valid,
    input  mmcrc_pkg::t_item    i_item,
    output logic                o_item_ready,
    input  mmcrc_pkg::t_cfg     i_cfg,
    input  wire                 i_reload,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [31:0]         o_crc_out,
    output logic [2:0]          o_crc_bytes
);

    logic [31:0] r_crc;
    logic        r_out_valid;
    logic [31:0] r_out_crc;
    logic [2:0]  r_out_bytes;

    logic [31:0] w_upd;
    logic [2:0]  w_nbytes;
    logic [31:0] w_start;
    logic        w_take;

    always_comb begin
        case (i_item.op)
            mmcrc_pkg::OP_CRC8: begin
                w_upd    = {24'd0, mmcrc_pkg::crc8_update(r_crc[7:0], i_item.data)};
                w_nbytes = mmcrc_pkg::BYTES_CRC8;
            end
            mmcrc_pkg::OP_CRC16: begin
                w_upd    = {16'd0, mmcrc_pkg::crc16_update(r_crc[15:0], i_item.data)};
                w_nbytes = mmcrc_pkg::BYTES_CRC16;
            end
            mmcrc_pkg::OP_CRC32: begin
                w_upd    = mmcrc_pkg::crc32_update(r_crc, i_item.data);
                w_nbytes = mmcrc_pkg::BYTES_CRC32;
            end
            default: begin
                w_upd    = 32'd0;
                w_nbytes = mmcrc_pkg::BYTES_NONE;
            end
        endcase
    end

    assign w_start      = mmcrc_pkg::start_value(i_cfg);
    // only a message end needs room in the result register
    assign o_item_ready = !i_item.last || !r_out_valid || i_ready;
    assign w_take       = i_item_valid && o_item_ready;

    assign o_valid     = r_out_valid;
    assign o_crc_out   = r_out_crc;
    assign o_crc_bytes = r_out_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_reload) begin
                r_crc <= w_start;
            end else if (w_take) begin
                if (i_item.last) begin
                    r_crc <= w_start;
                end else begin
                    r_crc <= w_upd;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_item.last) begin
            r_out_crc   <= w_upd;
            r_out_bytes <= w_nbytes;
        end
    end

endmodule
`default_nettype wire

### src/multi_mode_crc_engine.sv
// top level of the multi-mode crc engine: config registers, front and back ends
//
// channel   direction  signals                                  width
// input     in         i_valid/o_ready, i_data_byte, i_last_byte 8 + 1
// result    out        o_valid/i_ready, o_crc_out, o_crc_bytes   32 + 3
// config    in         i_cfg_valid/o_cfg_ready, i_cfg_index,     2 + 8
//                      i_cfg_data
//
// one byte per cycle unless a last byte stalls on i_ready; xor byte update in the back end
// each byte is held in the byte queue until the back end takes it; the result is registered
// the byte queue lets input requests continue while a result waits on i_ready
// synchronous active-low reset; crc8 mode with seed zero after reset, no clearing pass
// a mode or seed write reloads the running crc of the new mode on the following cycle
`default_nettype none
module multi_mode_crc_engine #(
    parameter int QUEUE_DEPTH = mmcrc_pkg::QUEUE_DEPTH
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [7:0]                         i_data_byte,
    input  wire                                i_last_byte,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic [31:0]                        o_crc_out,
    output logic [2:0]                         o_crc_bytes,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [mmcrc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire  [mmcrc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    mmcrc_pkg::t_cfg  r_cfg;
    logic             r_reload;
    logic             w_cfg_wr;
    logic             w_item_valid;
    logic             w_item_ready;
    mmcrc_pkg::t_item w_item;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= mmcrc_pkg::MODE_CRC8;
            r_cfg.seed <= 8'd0;
            r_reload   <= 1'b0;
        end else begin
            r_reload <= w_cfg_wr && ((i_cfg_index == mmcrc_pkg::REG_MODE) ||
                                     (i_cfg_index == mmcrc_pkg::REG_SEED));
            if (w_cfg_wr) begin
                case (i_cfg_index)
                    mmcrc_pkg::REG_MODE: begin
                        r_cfg.mode <= i_cfg_data[1:0];
                    end
                    mmcrc_pkg::REG_SEED: begin
                        r_cfg.seed <= i_cfg_data[7:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    mmcrc_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_cfg        (r_cfg),
        .o_item_valid (w_item_valid),
        .o_item       (w_item),
        .i_item_ready (w_item_ready)
    );

    mmcrc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_item_valid),
        .i_item       (w_item),
        .o_item_ready (w_item_ready),
        .i_cfg        (r_cfg),
        .i_reload     (r_reload),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_crc_out    (o_crc_out),
        .o_crc_bytes  (o_crc_bytes)
    );

endmodule
`default_nettype wire
